// ===== hw/rtl/acs_pkg.sv =====
// Shared types and constants of the affinity chunk scheduler.
package acs_pkg;

	localparam int ITER_W    = 21;  // iteration counts and bounds
	localparam int WRK_W     = 8;   // worker count register
	localparam int REQ_W     = 7;   // requester index field
	localparam int NUM_W     = 22;  // dividend of a rounded-up division
	localparam int DIV_STEPS = 22;  // one quotient bit per step
	localparam int STEP_W    = 5;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int REG_SEL_BIT = 2; // registers sit on 4-byte boundaries

	localparam logic [WRK_W-1:0]  WORKERS_RST = 8'd1;
	localparam logic [ITER_W-1:0] TOTAL_RST   = 21'd729;

	typedef enum logic {
		REG_WORKERS = 1'b0,
		REG_TOTAL   = 1'b1
	} reg_idx_t;

	typedef enum logic {
		MODE_START   = 1'b0,
		MODE_REQUEST = 1'b1
	} mode_t;

	typedef struct packed {
		logic [WRK_W-1:0]  worker_count;
		logic [ITER_W-1:0] total_iterations;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [WRK_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== hw/rtl/acs_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module acs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  acs_pkg::div_req_t req,
	output acs_pkg::div_rsp_t rsp
);
	import acs_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  quo_q;
	logic [WRK_W-1:0]  den_q;
	logic [WRK_W-1:0]  rem_q;
	logic [WRK_W:0]    rem_sh;
	logic [WRK_W:0]    rem_sub;
	logic              fits;

	// bring down the next dividend bit, quotient bits shift in behind it
	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(DIV_STEPS);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			busy_q <= (step_q != STEP_W'(1));
			done_q <= (step_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[WRK_W-1:0] : rem_sh[WRK_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== hw/rtl/acs_apb.sv =====
// Configuration registers behind an APB-style port.
module acs_apb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [acs_pkg::APB_AW-1:0]  paddr,
	input  logic [acs_pkg::APB_DW-1:0]  pwdata,
	output logic [acs_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output acs_pkg::cfg_t               cfg
);
	import acs_pkg::*;

	reg_idx_t          idx;
	logic [WRK_W-1:0]  workers_q;
	logic [ITER_W-1:0] total_q;

	assign idx    = reg_idx_t'(paddr[REG_SEL_BIT]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			workers_q <= WORKERS_RST;
			total_q   <= TOTAL_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_WORKERS: workers_q <= pwdata[WRK_W-1:0];
				REG_TOTAL:   total_q   <= pwdata[ITER_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WORKERS: prdata = APB_DW'(workers_q);
			REG_TOTAL:   prdata = APB_DW'(total_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.worker_count     = workers_q;
	assign cfg.total_iterations = total_q;

endmodule

// ===== hw/rtl/affinity_chunk_scheduler_top.sv =====
// Affinity chunk scheduler: block split on start, chunk grant or steal on request.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  input    | in_valid/in_stall  | mode, requester
//  output   | out_valid/out_stall| chunk_low, chunk_high, finished
//  config   | APB psel/penable   | worker_count @0x0, total_iterations @0x4
//
//  Start: the divider computes the block size, then the fill pass writes all
//  MAX_WORKERS entries, one per cycle, through the counter memory's write port.
//  Request on a worker's own block: one counter read, then the 22-step divider.
//  Request that steals: one memory read per cycle to find the fullest block
//  among the first W entries, W being the active worker count.
//  No clearing pass after reset: counters read as zero until the first start.
//  in_stall is high from acceptance until the result is in the output register;
//  a stalled result does not block acceptance of the next transaction.
module affinity_chunk_scheduler_top #(
	parameter int MAX_WORKERS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [acs_pkg::REQ_W-1:0]   requester,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [acs_pkg::ITER_W-1:0]  chunk_low,
	output logic [acs_pkg::ITER_W-1:0]  chunk_high,
	output logic                        finished,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [acs_pkg::APB_AW-1:0]  paddr,
	input  logic [acs_pkg::APB_DW-1:0]  pwdata,
	output logic [acs_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import acs_pkg::*;

	localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int SEL_W = $clog2(MAX_WORKERS + 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_BDIV = 7'b0000010,
		ST_FILL = 7'b0000100,
		ST_OWN  = 7'b0001000,
		ST_SCAN = 7'b0010000,
		ST_CDIV = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [WRK_W-1:0]  wrk;
	logic              in_acc;
	logic              out_load;

	logic [ITER_W-1:0] left_mem_q [MAX_WORKERS];
	logic [ITER_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  mem_raddr;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [ITER_W-1:0] mem_wdata;
	logic [ITER_W-1:0] rd_left;
	logic              started_q;

	logic              own_ok_q;
	logic [IDX_W-1:0]  victim_q;
	logic [ITER_W-1:0] left_q;
	logic [ITER_W-1:0] bs_q;
	logic [31:0]       acc_q;
	logic [ITER_W-1:0] prev_end_q;
	logic [IDX_W-1:0]  fill_q;
	logic [ITER_W-1:0] fill_end;
	logic              fill_last;
	logic [IDX_W-1:0]  cmp_q;
	logic [SEL_W-1:0]  cmp_nxt;
	logic              scan_last;
	logic [ITER_W-1:0] best_q;
	logic [ITER_W-1:0] best_nxt;
	logic [31:0]       prod_q;
	logic [ITER_W-1:0] end_q;
	logic [ITER_W-1:0] lo_q;
	logic [ITER_W-1:0] chunk;

	logic [ITER_W-1:0] res_low_q;
	logic [ITER_W-1:0] res_high_q;
	logic              res_fin_q;
	logic              out_valid_q;
	logic [ITER_W-1:0] chunk_low_q;
	logic [ITER_W-1:0] chunk_high_q;
	logic              finished_q;

	acs_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// clamp the worker count to 1..MAX_WORKERS
	always_comb begin
		if (cfg.worker_count == '0)
			wrk = WRK_W'(1);
		else if (32'(cfg.worker_count) > MAX_WORKERS)
			wrk = WRK_W'(MAX_WORKERS);
		else
			wrk = cfg.worker_count;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign rd_left   = started_q ? rd_data_q : '0;
	assign cmp_nxt   = SEL_W'(cmp_q) + SEL_W'(1);
	assign scan_last = (32'(cmp_nxt) == 32'(wrk));
	assign best_nxt  = (rd_left > best_q) ? rd_left : best_q;
	assign fill_end  = (acc_q > 32'(cfg.total_iterations)) ? cfg.total_iterations
	                                                        : acc_q[ITER_W-1:0];
	assign fill_last = (32'(fill_q) == MAX_WORKERS - 1);
	assign chunk     = div_rsp.quot[ITER_W-1:0];

	always_comb begin
		unique case (state_q)
			ST_OWN:  mem_raddr = '0;
			ST_SCAN: mem_raddr = cmp_nxt[IDX_W-1:0];
			default: mem_raddr = IDX_W'(requester);
		endcase
	end

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.den   = wrk;
		div_req.num   = NUM_W'(cfg.total_iterations) + NUM_W'(wrk) - NUM_W'(1);
		mem_we        = 1'b0;
		mem_waddr     = fill_q;
		mem_wdata     = (32'(fill_q) < 32'(wrk)) ? fill_end - prev_end_q : '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (mode == MODE_START) begin
						div_req.start = 1'b1;
						state_d       = ST_BDIV;
					end else begin
						state_d       = ST_OWN;
					end
				end
			end
			ST_BDIV: begin
				if (div_rsp.done)
					state_d = ST_FILL;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				if (fill_last)
					state_d = ST_DONE;
			end
			ST_OWN: begin
				div_req.num = NUM_W'(rd_left) + NUM_W'(wrk) - NUM_W'(1);
				if (own_ok_q && rd_left != '0) begin
					div_req.start = 1'b1;
					state_d       = ST_CDIV;
				end else begin
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				div_req.num = NUM_W'(best_nxt) + NUM_W'(wrk) - NUM_W'(1);
				if (scan_last) begin
					if (best_nxt != '0) begin
						div_req.start = 1'b1;
						state_d       = ST_CDIV;
					end else begin
						state_d       = ST_DONE;
					end
				end
			end
			ST_CDIV: begin
				mem_waddr = victim_q;
				mem_wdata = left_q - chunk;
				if (div_rsp.done) begin
					mem_we  = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_data_q <= left_mem_q[mem_raddr];
		if (mem_we)
			left_mem_q[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FILL && fill_last)
				started_q <= 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				own_ok_q <= (32'(requester) < MAX_WORKERS);
				victim_q <= IDX_W'(requester);
			end
			ST_BDIV: begin
				bs_q       <= chunk;
				acc_q      <= 32'(chunk);
				prev_end_q <= '0;
				fill_q     <= '0;
			end
			ST_FILL: begin
				// this block starts where the previous one ended
				acc_q      <= acc_q + 32'(bs_q);
				prev_end_q <= fill_end;
				fill_q     <= fill_q + IDX_W'(1);
				res_low_q  <= '0;
				res_high_q <= '0;
				res_fin_q  <= 1'b0;
			end
			ST_OWN: begin
				left_q <= rd_left;
				best_q <= '0;
				cmp_q  <= '0;
			end
			ST_SCAN: begin
				cmp_q  <= cmp_nxt[IDX_W-1:0];
				left_q <= best_nxt;
				best_q <= best_nxt;
				if (rd_left > best_q)
					victim_q <= cmp_q;
				res_low_q  <= '0;
				res_high_q <= '0;
				res_fin_q  <= 1'b1;
			end
			ST_CDIV: begin
				// block end settles long before the divider finishes
				prod_q <= 32'(bs_q) * (32'(victim_q) + 32'd1);
				end_q  <= (prod_q > 32'(cfg.total_iterations)) ? cfg.total_iterations
				                                                 : prod_q[ITER_W-1:0];
				lo_q   <= end_q - left_q;
				res_low_q  <= lo_q;
				res_high_q <= lo_q + chunk;
				res_fin_q  <= 1'b0;
			end
			ST_DONE: begin
				if (out_load) begin
					chunk_low_q  <= res_low_q;
					chunk_high_q <= res_high_q;
					finished_q   <= res_fin_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign chunk_low  = chunk_low_q;
	assign chunk_high = chunk_high_q;
	assign finished   = finished_q;

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_BDIV || state_q == ST_CDIV))
		else $error("divider result outside a division state");

	a_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_FILL || (state_q == ST_CDIV && div_rsp.done)))
		else $error("counter memory written outside fill or grant");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> 32'(cmp_q) < 32'(wrk))
		else $error("scan beyond the active workers");

	a_started_holds: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("run flag dropped");

	a_finished_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && finished_q |-> chunk_low_q == '0 && chunk_high_q == '0)
		else $error("finished result with a non-empty chunk");

endmodule

// ===== tb/affinity_chunk_scheduler_top_test.sv =====
// Self-checking testbench for the affinity chunk scheduler: chunk grant prediction and checks.
`timescale 1ns / 100ps

module affinity_chunk_scheduler_top_test;
	import acs_pkg::*;

	localparam int          NUM_WORKERS = 128;
	localparam int          ITEM_TARGET = 1375;
	localparam int unsigned CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [ITER_W-1:0] lo;
		logic [ITER_W-1:0] hi;
		logic              fin;
	} grant_t;

	// Tracks the per-worker blocks and queues the grant each transaction must produce.
	class affinity_ledger;
		logic [WRK_W-1:0]  workers;
		logic [ITER_W-1:0] total;
		logic [ITER_W-1:0] blk;
		logic [ITER_W-1:0] left_iters [NUM_WORKERS];
		grant_t            grants_due [$];
		int unsigned       mismatches;
		int unsigned       checked;
		int unsigned       finishes;

		function new();
			workers = WORKERS_RST;
			total   = TOTAL_RST;
			blk     = '0;
			foreach (left_iters[i]) left_iters[i] = '0;
			mismatches = 0;
			checked    = 0;
			finishes   = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] d);
			case (idx)
				REG_WORKERS: workers = d[WRK_W-1:0];
				REG_TOTAL:   total   = d[ITER_W-1:0];
			endcase
		endfunction

		function int unsigned active_count();
			int unsigned w;
			w = workers;
			if (w == 0) w = 1;
			if (w > NUM_WORKERS) w = NUM_WORKERS;
			return w;
		endfunction

		// End of a block under the current block size, clipped to the iteration count.
		function logic [ITER_W-1:0] block_limit(int unsigned idx);
			longint unsigned e;
			e = blk;
			e = e * (idx + 1);
			if (e > total) e = total;
			return e[ITER_W-1:0];
		endfunction

		function void note_item(mode_t m, logic [REQ_W-1:0] r);
			grant_t            g;
			int unsigned       w, i, victim, best, lft, chunk;
			bit                found;
			longint unsigned   s;
			logic [ITER_W-1:0] st;
			g = '0;
			w = active_count();
			if (m == MODE_START) begin
				blk = ITER_W'((total + w - 1) / w);
				for (i = 0; i < NUM_WORKERS; i++) begin
					if (i < w) begin
						s  = blk;
						s  = s * i;
						st = (s > total) ? total : s[ITER_W-1:0];
						left_iters[i] = block_limit(i) - st;
					end else begin
						left_iters[i] = '0;
					end
				end
			end else begin
				found  = 1'b0;
				victim = 0;
				if (left_iters[r] != 0) begin
					victim = r;
					found  = 1'b1;
				end else begin
					// steal from the fullest block, lowest index on a tie
					best = 0;
					for (i = 0; i < w; i++) begin
						if (left_iters[i] > best) begin
							best   = left_iters[i];
							victim = i;
							found  = 1'b1;
						end
					end
				end
				if (!found) begin
					g.fin = 1'b1;
				end else begin
					lft   = left_iters[victim];
					chunk = (lft + w - 1) / w;
					g.lo  = block_limit(victim) - ITER_W'(lft);
					g.hi  = g.lo + ITER_W'(chunk);
					left_iters[victim] = ITER_W'(lft - chunk);
				end
			end
			grants_due.push_back(g);
		endfunction

		function void check_grant(logic [ITER_W-1:0] lo, logic [ITER_W-1:0] hi, logic fin);
			grant_t g;
			if (grants_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %0d: unexpected result lo=%0d hi=%0d fin=%0b",
						mismatches, lo, hi, fin);
				return;
			end
			g = grants_due.pop_front();
			checked++;
			if (g.fin) finishes++;
			if (lo !== g.lo || hi !== g.hi || fin !== g.fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %0d: expected lo=%0d hi=%0d fin=%0b, got lo=%0d hi=%0d fin=%0b",
						mismatches, g.lo, g.hi, g.fin, lo, hi, fin);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                mode;
	logic [REQ_W-1:0]    requester;
	logic                out_valid;
	logic                out_stall;
	logic [ITER_W-1:0]   chunk_low;
	logic [ITER_W-1:0]   chunk_high;
	logic                finished;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	affinity_ledger ledger;
	int unsigned    cycles;
	int unsigned    burst_left;
	int unsigned    n_starts;
	int unsigned    n_requests;
	int unsigned    n_writes;
	int unsigned    stall_style;
	int unsigned    stall_run;

	affinity_chunk_scheduler_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.requester  (requester),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chunk_low  (chunk_low),
		.chunk_high (chunk_high),
		.finished   (finished),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, ledger.grants_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: check each transaction, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				ledger.check_grant(chunk_low, chunk_high, finished);
			if (stall_run == 0) begin
				stall_style = $urandom_range(0, 2);
				stall_run   = $urandom_range(20, 200);
			end
			stall_run--;
			case (stall_style)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 2) == 0);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic send_item(mode_t m, logic [REQ_W-1:0] r);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		mode      <= m;
		requester <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ledger.note_item(m, r);
		burst_left--;
		if (m == MODE_START) n_starts++;
		else n_requests++;
	endtask

	// Hold the sender until every outstanding grant has come back.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ledger.grants_due.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] d;
		d = ($urandom_range(0, 1) == 0) ? '0 : APB_DW'($urandom);
		if (idx == REG_WORKERS) d[WRK_W-1:0] = value[WRK_W-1:0];
		else d[ITER_W-1:0] = value[ITER_W-1:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(int'(idx) << REG_SEL_BIT);
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		ledger.set_reg(idx, d);
		n_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [WRK_W-1:0] w, logic [ITER_W-1:0] t);
		apb_write(REG_WORKERS, APB_DW'(w));
		apb_write(REG_TOTAL, APB_DW'(t));
	endtask

	function automatic logic [WRK_W-1:0] pick_workers();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 8) return WRK_W'($urandom_range(1, 4));
		if (r < 13) return WRK_W'($urandom_range(5, 16));
		if (r < 16) return WRK_W'($urandom_range(17, 128));
		if (r == 16) return WRK_W'(128);
		if (r == 17) return '0;
		if (r == 18) return WRK_W'($urandom_range(129, 255));
		return WRK_W'(1);
	endfunction

	// Mostly short loops so that runs drain to the finished state.
	function automatic logic [ITER_W-1:0] pick_total();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 9) return ITER_W'($urandom_range(1, 40));
		if (r == 9) return '0;
		if (r < 14) return ITER_W'($urandom_range(41, 3000));
		if (r < 17) return ITER_W'($urandom_range(3001, 1048575));
		if (r == 17) return ITER_W'(1048576);
		if (r == 18) return ITER_W'($urandom_range(1048577, 2097151));
		return ITER_W'(1);
	endfunction

	initial begin
		logic [REQ_W-1:0] drain_picks [9];
		int unsigned      nreq, k, w;
		drain_picks = '{7'd2, 7'd2, 7'd1, 7'd0, 7'd100, 7'd1, 7'd0, 7'd2, 7'd2};
		ledger      = new();
		cycles      = 0;
		burst_left  = 0;
		n_starts    = 0;
		n_requests  = 0;
		n_writes    = 0;
		stall_style = 0;
		stall_run   = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = 1'b0;
		requester   = '0;
		out_stall   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// requests before any start, then a single worker owning the whole loop
		send_item(MODE_REQUEST, 7'd0);
		send_item(MODE_REQUEST, 7'd127);
		send_item(MODE_START, 7'd0);
		send_item(MODE_REQUEST, 7'd5);
		send_item(MODE_REQUEST, 7'd0);
		// zero workers acts as one, zero iterations leaves nothing to grant
		quiesce();
		set_config('0, '0);
		send_item(MODE_START, 7'd127);
		send_item(MODE_REQUEST, 7'd3);
		// worker count above the pool, largest iteration count
		quiesce();
		set_config(8'd255, 21'h1FFFFF);
		send_item(MODE_START, 7'd0);
		send_item(MODE_REQUEST, 7'd127);
		send_item(MODE_REQUEST, 7'd0);
		send_item(MODE_REQUEST, 7'd64);
		quiesce();
		set_config(8'd129, 21'd1048576);
		send_item(MODE_START, 7'd0);
		send_item(MODE_REQUEST, 7'd127);
		// clipped last block, tied steals, outside requester, run to empty pool
		quiesce();
		set_config(8'd3, 21'd7);
		send_item(MODE_START, 7'd0);
		foreach (drain_picks[i]) send_item(MODE_REQUEST, drain_picks[i]);
		// registers changed mid-run wrap the chunk bounds
		quiesce();
		set_config(8'd2, 21'd10);
		send_item(MODE_START, 7'd0);
		quiesce();
		set_config(8'd4, 21'd3);
		send_item(MODE_REQUEST, 7'd0);
		send_item(MODE_REQUEST, 7'd3);

		while (n_starts + n_requests < ITEM_TARGET) begin
			quiesce();
			if ($urandom_range(0, 3) != 0) set_config(pick_workers(), pick_total());
			send_item(MODE_START, REQ_W'($urandom));
			if ($urandom_range(0, 4) == 0) begin
				quiesce();
				if ($urandom_range(0, 1) == 0) apb_write(REG_WORKERS, APB_DW'(pick_workers()));
				else apb_write(REG_TOTAL, APB_DW'(pick_total()));
			end
			// short loops get enough requests to drain every block
			nreq = (ledger.total <= 40) ? ledger.total + $urandom_range(1, 6)
				: $urandom_range(5, 60);
			for (k = 0; k < nreq; k++) begin
				w = ledger.active_count();
				if ($urandom_range(0, 39) == 0)
					send_item(MODE_START, REQ_W'($urandom));
				else if ($urandom_range(0, 9) < 7)
					send_item(MODE_REQUEST, REQ_W'($urandom_range(0, w - 1)));
				else
					send_item(MODE_REQUEST, REQ_W'($urandom));
			end
		end

		quiesce();
		repeat (300) @(posedge clk);
		$display("%0d loop starts and %0d chunk requests over %0d register writes",
			n_starts, n_requests, n_writes);
		$display("%0d results checked, %0d with no work left, %0d mismatches",
			ledger.checked, ledger.finishes, ledger.mismatches);
		if (ledger.mismatches == 0 && ledger.grants_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/acs_pkg.sv
hw/rtl/acs_div.sv
hw/rtl/acs_apb.sv
hw/rtl/affinity_chunk_scheduler_top.sv
tb/affinity_chunk_scheduler_top_test.sv
